[design/assert_macros.svh]
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/ebdh_pkg.sv]
// shared types and constants of the event buffer deframer
package ebdh_pkg;

	localparam int DEF_CHANNELS   = 4;
	localparam int DEF_BINS       = 4096;
	localparam int DEF_COUNT_BITS = 32;

	localparam int WORD_W  = 16;
	localparam int LEN_W   = 12;
	localparam int CHAN_W  = 2;
	localparam int BINIX_W = 13;
	localparam int OUTC_W  = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [1:0] OP_WORD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] KIND_BUF_HDR = 3'd0;
	localparam logic [2:0] KIND_EVT_HDR = 3'd1;
	localparam logic [2:0] KIND_HIST    = 3'd2;
	localparam logic [2:0] KIND_IGNORED = 3'd3;
	localparam logic [2:0] KIND_TERM    = 3'd4;
	localparam logic [2:0] KIND_TRAIL   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_TERM   = 2'd1;
	localparam logic [1:0] ST_TRAILING  = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	localparam logic [WORD_W-1:0] TERM_WORD  = 16'hFFFF;
	localparam int                SCALER_BIT = 13;
	localparam logic [LEN_W-1:0]  EXP_RESET  = 12'd12;
	localparam logic              REG_EXP    = 1'b0;

	typedef struct packed {
		logic [2:0]        kind;
		logic              rejected;
		logic              done;
		logic [1:0]        status;
		logic [WORD_W-1:0] events;
		logic              inc;
		logic [LEN_W-1:0]  pos;
	} parse_res_t;

endpackage

[design/event_buffer_deframer_histogram.sv]
// top level of the event buffer deframer with channel histograms
// Takes a length-prefixed readout buffer one 16-bit word per transfer and
// classifies each word; data words of accepted ADC events count into a
// per-channel histogram held in one single-port-write memory of
// CHANNELS*(BINS+1) bins. Buffer words and bin reads run at one transfer per
// cycle unless the output is held or a clear waits or sweeps, with write-back
// forwarding on the memory read; a result passes the stage-1 and output
// registers. After reset and each clear the memory is swept one bin per cycle
// over all CHANNELS*(BINS+1) bins (16388 by default); from a clear's transfer
// until its sweep ends no transfer is taken; register writes are always taken.
module event_buffer_deframer_histogram #(
	parameter int CHANNELS   = ebdh_pkg::DEF_CHANNELS,
	parameter int BINS       = ebdh_pkg::DEF_BINS,
	parameter int COUNT_BITS = ebdh_pkg::DEF_COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // word, channel, bin_index
	input  logic [1:0]                   s_axis_tuser,  // operation
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [55:0]                  m_axis_tdata,  // event_rejected, buffer_status, events_in_buffer, bin_count
	output logic [2:0]                   m_axis_tuser,  // word_kind
	output logic                         m_axis_tlast,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ebdh_pkg::PADDR_W-1:0] paddr,
	input  logic [ebdh_pkg::PDATA_W-1:0] pwdata,
	output logic [ebdh_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import ebdh_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BIN_W = $clog2(BINS + 1);

	logic [LEN_W-1:0]      exp_q;
	logic [1:0]            op;
	logic [WORD_W-1:0]     word;
	logic [CHAN_W-1:0]     channel;
	logic [BINIX_W-1:0]    bin_index;
	logic                  accept;
	logic                  advance;
	logic                  commit;
	logic                  busy;
	parse_res_t            pres;
	parse_res_t            res;
	logic                  rd_ok;
	logic                  req_inc;
	logic [CH_W-1:0]       req_ch;
	logic [BIN_W-1:0]      req_bin;
	logic [COUNT_BITS-1:0] count;
	logic [OUTC_W-1:0]     count32;

	logic                  valid_s1;
	parse_res_t            res_s1;
	logic                  rd_s1;
	logic                  clr_s1;

	logic                  m_valid_q;
	logic [2:0]            kind_q;
	logic                  rej_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [WORD_W-1:0]     events_q;
	logic [OUTC_W-1:0]     bin_count_q;

	assign op        = s_axis_tuser;
	assign word      = s_axis_tdata[15:0];
	assign channel   = s_axis_tdata[17:16];
	assign bin_index = s_axis_tdata[30:18];

	assign advance       = !m_valid_q | m_axis_tready;
	assign commit        = valid_s1 & advance;
	// a clear waiting to start its sweep holds the input
	assign s_axis_tready = (!valid_s1 | advance) & !busy & !(valid_s1 & clr_s1);
	assign accept        = s_axis_tvalid & s_axis_tready;

	ebdh_parser #(
		.CHANNELS(CHANNELS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (accept && (op == OP_WORD)),
		.word     (word),
		.last     (s_axis_tlast),
		.expected (exp_q),
		.res      (pres)
	);

	always_comb begin
		res     = (op == OP_WORD) ? pres : '0;
		rd_ok   = (op == OP_READ) && (32'(channel) < 32'(CHANNELS))
			&& (32'(bin_index) <= 32'(BINS));
		req_inc = (op == OP_WORD) && pres.inc;
		if (op == OP_WORD) begin
			req_ch  = CH_W'(pres.pos);
			req_bin = (32'(word) < 32'(BINS)) ? BIN_W'(word) : BIN_W'(BINS);
		end else begin
			req_ch  = CH_W'(channel);
			req_bin = BIN_W'(bin_index);
		end
	end

	ebdh_hist #(
		.CHANNELS   (CHANNELS),
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_hist (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (accept),
		.req_inc     (req_inc),
		.req_ch      (req_ch),
		.req_bin     (req_bin),
		.commit      (commit),
		.clear_start (commit & clr_s1),
		.busy        (busy),
		.count       (count)
	);

	generate
		if (COUNT_BITS > OUTC_W) begin : g_sat
			assign count32 = (|count[COUNT_BITS-1:OUTC_W]) ? {OUTC_W{1'b1}}
				: count[OUTC_W-1:0];
		end else begin : g_ext
			assign count32 = OUTC_W'(count);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			rd_s1  <= rd_ok;
			clr_s1 <= (op == OP_CLEAR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			kind_q      <= res_s1.kind;
			rej_q       <= res_s1.rejected;
			done_q      <= res_s1.done;
			status_q    <= res_s1.status;
			events_q    <= res_s1.events;
			bin_count_q <= rd_s1 ? count32 : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = done_q;
	assign m_axis_tdata  = {5'd0, bin_count_q, events_q, status_q, rej_q};

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EXP) ? PDATA_W'(exp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= EXP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EXP)) begin
			exp_q <= pwdata[LEN_W-1:0];
		end
	end

endmodule

[design/ebdh_parser.sv]
// buffer framing state machine
module ebdh_parser #(
	parameter int CHANNELS = ebdh_pkg::DEF_CHANNELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [ebdh_pkg::WORD_W-1:0] word,
	input  logic                       last,
	input  logic [ebdh_pkg::LEN_W-1:0]  expected,
	output ebdh_pkg::parse_res_t       res
);
	import ebdh_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_EVENT,
		PH_DATA,
		PH_TERM,
		PH_TRAIL
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [WORD_W-1:0] events_q, events_n;
	logic [LEN_W-1:0]  words_q, words_n;
	logic [LEN_W-1:0]  pos_q, pos_n;
	logic              adc_q, adc_n;
	logic              trail_q, trail_n;
	logic              noterm_q, noterm_n;
	logic [LEN_W-1:0]  len;
	logic              scaler;

	always_comb begin
		len      = word[LEN_W-1:0];
		scaler   = word[SCALER_BIT];
		phase_n  = phase_q;
		events_n = events_q;
		words_n  = words_q;
		pos_n    = pos_q;
		adc_n    = adc_q;
		trail_n  = trail_q;
		noterm_n = noterm_q;
		res      = '0;
		res.pos  = pos_q;
		case (phase_q)
			PH_HEADER: begin
				res.kind   = KIND_BUF_HDR;
				res.events = word;
				events_n   = word;
				phase_n    = (word != '0) ? PH_EVENT : PH_TERM;
			end
			PH_EVENT: begin
				res.kind     = KIND_EVT_HDR;
				adc_n        = !scaler && (len == expected);
				res.rejected = !scaler && (len != expected);
				words_n      = len;
				pos_n        = '0;
				events_n     = events_q - WORD_W'(1);
				if (len == '0) begin
					phase_n = (events_n != '0) ? PH_EVENT : PH_TERM;
				end else begin
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				if (adc_q && (32'(pos_q) < 32'(CHANNELS))) begin
					res.kind = KIND_HIST;
					res.inc  = 1'b1;
				end else begin
					res.kind = KIND_IGNORED;
				end
				pos_n   = pos_q + LEN_W'(1);
				words_n = words_q - LEN_W'(1);
				if (words_n == '0) begin
					phase_n = (events_q != '0) ? PH_EVENT : PH_TERM;
				end
			end
			PH_TERM: begin
				res.kind = KIND_TERM;
				if (word != TERM_WORD) begin
					noterm_n = 1'b1;
				end
				phase_n = PH_TRAIL;
			end
			default: begin
				res.kind = KIND_TRAIL;
				trail_n  = 1'b1;
				phase_n  = PH_TRAIL;
			end
		endcase
		if (last) begin
			res.done = 1'b1;
			if (phase_n != PH_TRAIL) begin
				res.status = ST_TRUNCATED;
			end else if (noterm_n) begin
				res.status = ST_NO_TERM;
			end else if (trail_n) begin
				res.status = ST_TRAILING;
			end else begin
				res.status = ST_OK;
			end
			phase_n  = PH_HEADER;
			events_n = '0;
			words_n  = '0;
			pos_n    = '0;
			adc_n    = 1'b0;
			trail_n  = 1'b0;
			noterm_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			events_q <= '0;
			words_q  <= '0;
			pos_q    <= '0;
			adc_q    <= 1'b0;
			trail_q  <= 1'b0;
			noterm_q <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_n;
			events_q <= events_n;
			words_q  <= words_n;
			pos_q    <= pos_n;
			adc_q    <= adc_n;
			trail_q  <= trail_n;
			noterm_q <= noterm_n;
		end
	end

endmodule

[design/ebdh_hist.sv]
// histogram memory with read-modify-write, forwarding and clearing pass
module ebdh_hist #(
	parameter int CHANNELS   = ebdh_pkg::DEF_CHANNELS,
	parameter int BINS       = ebdh_pkg::DEF_BINS,
	parameter int COUNT_BITS = ebdh_pkg::DEF_COUNT_BITS,
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int BIN_W     = $clog2(BINS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req,
	input  logic                  req_inc,
	input  logic [CH_W-1:0]       req_ch,
	input  logic [BIN_W-1:0]      req_bin,
	input  logic                  commit,
	input  logic                  clear_start,
	output logic                  busy,
	output logic [COUNT_BITS-1:0] count
);
	import ebdh_pkg::*;

	localparam int SLOTS = BINS + 1;
	localparam int DEPTH = CHANNELS * SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [COUNT_BITS-1:0] MAXC = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] mem_q [DEPTH];
	logic [COUNT_BITS-1:0] rdata_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;
	logic                  fwd_hit_s1;
	logic [AW-1:0]         addr_s1;
	logic                  inc_s1;
	logic                  clr_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic                  we;

	assign raddr = AW'(req_ch) * AW'(SLOTS) + AW'(req_bin);
	assign count = fwd_hit_s1 ? fwd_data_s1 : rdata_s1;
	assign we    = clr_q | (commit & inc_s1);
	assign waddr = clr_q ? clr_cnt_q : addr_s1;
	assign wdata = clr_q ? '0 : ((count == MAXC) ? count : count + COUNT_BITS'(1));
	assign busy  = clr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (req) begin
			rdata_s1    <= mem_q[raddr];
			fwd_hit_s1  <= we && (waddr == raddr);
			fwd_data_s1 <= wdata;
			addr_s1     <= raddr;
			inc_s1      <= req_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_start) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

endmodule

[design/ebdh_checker.sv]
// port checks for the event buffer deframer, bound to the top level
`include "assert_macros.svh"

module ebdh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import ebdh_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
	`ASSERT_SAME(a_status_on_close, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[2:1] == ST_OK)
	`ASSERT_SAME(a_events_on_header, clk, arst_n, m_axis_tvalid && (m_axis_tdata[18:3] != '0), m_axis_tuser == KIND_BUF_HDR)
	`ASSERT_SAME(a_count_on_read, clk, arst_n, m_axis_tvalid && (m_axis_tdata[50:19] != '0), (m_axis_tuser == KIND_BUF_HDR) && !m_axis_tlast)
	`ASSERT_SAME(a_reject_on_event, clk, arst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tuser == KIND_EVT_HDR)

endmodule

bind event_buffer_deframer_histogram ebdh_checker u_ebdh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

[sim/tb_top.sv]
// testbench of the event buffer deframer: directed and random buffers against a predictor
module tb_top;
	import ebdh_pkg::*;

	localparam int         N_CHAN      = DEF_CHANNELS;
	localparam int         N_BINS      = DEF_BINS;
	localparam longint     CYCLE_LIMIT = 1500000;
	localparam int         ITEM_TARGET = 1150;
	localparam int         HOLD_CYCLES = 400;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	typedef enum logic [2:0] {
		PS_BUF_HDR,
		PS_EVT_HDR,
		PS_DATA,
		PS_TERM,
		PS_TRAIL
	} parse_state_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [WORD_W-1:0]  word;
		logic               last;
		logic [CHAN_W-1:0]  chan;
		logic [BINIX_W-1:0] bin;
	} buf_item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic              rejected;
		logic              done;
		logic [1:0]        status;
		logic [WORD_W-1:0] events;
		logic [OUTC_W-1:0] count;
	} word_result_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata;  // word, channel, bin_index
	logic [1:0]         s_axis_tuser;  // operation
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [55:0]        m_axis_tdata;  // event_rejected, buffer_status, events_in_buffer, bin_count
	logic [2:0]         m_axis_tuser;  // word_kind
	logic               m_axis_tlast;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	word_result_t expected_q[$];
	int           fail_count;
	int           items_sent;
	int           clears_left;
	longint       cycle_count;
	bit           quiet;
	bit           hold_req;

	// predictor state
	logic [LEN_W-1:0]  exp_words;
	parse_state_t      ps;
	logic [WORD_W-1:0] evts_left;
	logic [LEN_W-1:0]  wleft;
	logic [LEN_W-1:0]  wpos;
	logic              adc_evt;
	logic              trail_seen;
	logic              term_bad;
	logic [OUTC_W-1:0] hist [N_CHAN][N_BINS+1];

	event_buffer_deframer_histogram uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_hist();
		for (int c = 0; c < N_CHAN; c++)
			for (int b = 0; b <= N_BINS; b++)
				hist[c][b] = '0;
	endfunction

	function automatic void reset_parser();
		ps         = PS_BUF_HDR;
		evts_left  = '0;
		wleft      = '0;
		wpos       = '0;
		adc_evt    = 1'b0;
		trail_seen = 1'b0;
		term_bad   = 1'b0;
	endfunction

	function automatic void count_bin(int c, logic [WORD_W-1:0] v);
		int b;
		b = (v < N_BINS) ? int'(v) : N_BINS;
		if (hist[c][b] != '1)
			hist[c][b] = hist[c][b] + 1'b1;
	endfunction

	function automatic word_result_t predict_word(buf_item_t it);
		word_result_t r;
		logic [LEN_W-1:0] len;
		logic scaler;
		r = '0;
		if (it.op == OP_READ) begin
			if (it.chan < N_CHAN && it.bin <= N_BINS)
				r.count = hist[it.chan][it.bin];
			return r;
		end
		if (it.op == OP_CLEAR) begin
			clear_hist();
			return r;
		end
		if (it.op != OP_WORD)
			return r;
		case (ps)
			PS_BUF_HDR: begin
				r.kind    = KIND_BUF_HDR;
				r.events  = it.word;
				evts_left = it.word;
				ps        = (evts_left != 0) ? PS_EVT_HDR : PS_TERM;
			end
			PS_EVT_HDR: begin
				len       = it.word[LEN_W-1:0];
				scaler    = it.word[SCALER_BIT];
				r.kind    = KIND_EVT_HDR;
				adc_evt   = !scaler && len == exp_words;
				r.rejected = !scaler && len != exp_words;
				wleft     = len;
				wpos      = '0;
				evts_left = evts_left - 1'b1;
				if (len == 0)
					ps = (evts_left != 0) ? PS_EVT_HDR : PS_TERM;
				else
					ps = PS_DATA;
			end
			PS_DATA: begin
				if (adc_evt && wpos < N_CHAN) begin
					count_bin(int'(wpos), it.word);
					r.kind = KIND_HIST;
				end else begin
					r.kind = KIND_IGNORED;
				end
				wpos  = wpos + 1'b1;
				wleft = wleft - 1'b1;
				if (wleft == 0)
					ps = (evts_left != 0) ? PS_EVT_HDR : PS_TERM;
			end
			PS_TERM: begin
				r.kind = KIND_TERM;
				if (it.word != TERM_WORD)
					term_bad = 1'b1;
				ps = PS_TRAIL;
			end
			default: begin
				r.kind     = KIND_TRAIL;
				trail_seen = 1'b1;
				ps         = PS_TRAIL;
			end
		endcase
		if (it.last) begin
			r.done = 1'b1;
			if (ps != PS_TRAIL)
				r.status = ST_TRUNCATED;
			else if (term_bad)
				r.status = ST_NO_TERM;
			else if (trail_seen)
				r.status = ST_TRAILING;
			else
				r.status = ST_OK;
			reset_parser();
		end
		return r;
	endfunction

	function automatic buf_item_t mk_word(logic [WORD_W-1:0] w, logic last);
		buf_item_t it;
		it      = '0;
		it.op   = OP_WORD;
		it.word = w;
		it.last = last;
		it.chan = CHAN_W'($urandom());
		it.bin  = BINIX_W'($urandom());
		return it;
	endfunction

	function automatic buf_item_t mk_op(logic [1:0] op, logic [CHAN_W-1:0] c,
			logic [BINIX_W-1:0] b);
		buf_item_t it;
		it      = '0;
		it.op   = op;
		it.word = WORD_W'($urandom());
		it.last = 1'($urandom());
		it.chan = c;
		it.bin  = b;
		return it;
	endfunction

	task automatic send_item(buf_item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tlast  <= it.last;
		s_axis_tdata  <= {1'b0, it.bin, it.chan, it.word};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_q.insert(expected_q.size(), predict_word(it));
		items_sent++;
		if (!quiet && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_expected_words(logic [LEN_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_EXP, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		exp_words = v;
	endtask

	function automatic logic [BINIX_W-1:0] pick_bin();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return BINIX_W'($urandom_range(15));
		else if (r < 75)
			return BINIX_W'(N_BINS);
		else if (r < 85)
			return BINIX_W'($urandom_range(N_BINS + 4, N_BINS - 6));
		return BINIX_W'($urandom());
	endfunction

	function automatic logic [WORD_W-1:0] pick_data();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return WORD_W'($urandom_range(15));
		else if (r < 70)
			return WORD_W'($urandom_range(N_BINS + 4, N_BINS - 6));
		return WORD_W'($urandom());
	endfunction

	// buffer words with reads, unused operations and rare clears mixed in
	task automatic send_words(logic [WORD_W-1:0] words[$]);
		int r;
		for (int i = 0; i < words.size(); i++) begin
			r = $urandom_range(999);
			if (r < 50)
				send_item(mk_op(OP_READ, CHAN_W'($urandom()), pick_bin()));
			else if (r < 60)
				send_item(mk_op(OP_UNUSED, CHAN_W'($urandom()), BINIX_W'($urandom())));
			else if (r < 63 && clears_left > 0) begin
				clears_left--;
				send_item(mk_op(OP_CLEAR, CHAN_W'($urandom()), BINIX_W'($urandom())));
			end
			send_item(mk_word(words[i], i == words.size() - 1));
		end
	endtask

	task automatic send_random_buffer();
		logic [WORD_W-1:0] words[$];
		logic [WORD_W-1:0] hdr;
		int shape;
		int n_evt;
		int len;
		int r;
		int cut;
		shape = $urandom_range(99);
		if (shape < 8) begin
			repeat ($urandom_range(8, 1))
				words.insert(words.size(), WORD_W'($urandom()));
			send_words(words);
			return;
		end
		n_evt = $urandom_range(4);
		words.insert(words.size(), WORD_W'(n_evt));
		for (int e = 0; e < n_evt; e++) begin
			r   = $urandom_range(99);
			hdr = WORD_W'($urandom()) & 16'hD000;
			if (r < 50 && exp_words <= 40) begin
				len = exp_words;
			end else if (r < 70) begin
				len = $urandom_range(6);
				hdr[SCALER_BIT] = 1'b1;
			end else if (r < 90) begin
				len = $urandom_range(8);
			end else begin
				len = 0;
			end
			hdr[LEN_W-1:0] = LEN_W'(len);
			words.insert(words.size(), hdr);
			repeat (len)
				words.insert(words.size(), pick_data());
		end
		words.insert(words.size(),
			($urandom_range(99) < 85) ? TERM_WORD : WORD_W'($urandom()));
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(3, 1))
				words.insert(words.size(), WORD_W'($urandom()));
		if (shape < 18) begin
			cut = $urandom_range(words.size() - 1);
			while (words.size() > cut + 1)
				void'(words.pop_back());
		end
		send_words(words);
	endtask

	task automatic test_reset_setting();
		send_item(mk_word(16'd1, 1'b0));
		send_item(mk_word(16'hD000, 1'b0));
		send_item(mk_word(TERM_WORD, 1'b1));
		wait_drained();
	endtask

	task automatic test_directed();
		write_expected_words(12'd4);
		// accepted event, scaler event, bad terminator, one trailing word
		send_item(mk_word(16'd2, 1'b0));
		send_item(mk_word(16'h1004, 1'b0));
		send_item(mk_word(16'd0, 1'b0));
		send_item(mk_word(16'd4095, 1'b0));
		send_item(mk_word(16'd4096, 1'b0));
		send_item(mk_word(16'hFFFF, 1'b0));
		send_item(mk_word(16'hE002, 1'b0));
		send_item(mk_word(16'h1111, 1'b0));
		send_item(mk_word(16'h2222, 1'b0));
		send_item(mk_word(16'h1234, 1'b0));
		send_item(mk_word(16'h0000, 1'b1));
		// rejected event, good terminator, trailing word
		send_item(mk_word(16'd1, 1'b0));
		send_item(mk_word(16'h0001, 1'b0));
		send_item(mk_word(16'd7, 1'b0));
		send_item(mk_word(TERM_WORD, 1'b0));
		send_item(mk_word(16'd0, 1'b1));
		// buffer ends inside an event
		send_item(mk_word(16'd4, 1'b0));
		send_item(mk_word(16'h0004, 1'b0));
		send_item(mk_word(16'd9, 1'b1));
		send_item(mk_op(OP_READ, 2'd0, 13'd0));
		send_item(mk_op(OP_READ, 2'd1, 13'd4095));
		send_item(mk_op(OP_READ, 2'd3, 13'd4096));
		send_item(mk_op(OP_READ, 2'd0, 13'd8191));
		send_item(mk_op(OP_UNUSED, 2'd3, 13'd0));
		send_item(mk_op(OP_CLEAR, 2'd0, 13'd0));
		send_item(mk_op(OP_READ, 2'd1, 13'd4095));
		wait_drained();
	endtask

	task automatic test_short_events();
		write_expected_words(12'd1);
		repeat (12)
			send_random_buffer();
		wait_drained();
		write_expected_words(12'd3);
		repeat (12)
			send_random_buffer();
		wait_drained();
	endtask

	task automatic test_longest_event();
		logic [WORD_W-1:0] words[$];
		write_expected_words(12'd4095);
		words.insert(words.size(), 16'd1);
		words.insert(words.size(), 16'h0FFF);
		repeat (10)
			words.insert(words.size(), pick_data());
		send_words(words);
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_expected_words(12'd4);
		hold_req = 1'b1;
		repeat (15)
			send_random_buffer();
		wait_drained();
	endtask

	task automatic test_random();
		logic [LEN_W-1:0] settings[$];
		int phase;
		int phase_start;
		settings = '{12'd12, 12'd2, 12'd4095, 12'd5, 12'd1, 12'd4, 12'd7, 12'd0};
		phase = 0;
		clears_left = 3;
		while (items_sent < ITEM_TARGET) begin
			if (settings[phase % settings.size()] == 0)
				write_expected_words(LEN_W'($urandom_range(20, 1)));
			else
				write_expected_words(settings[phase % settings.size()]);
			quiet = (phase == 1);
			phase_start = items_sent;
			while (items_sent - phase_start < 120 && items_sent < ITEM_TARGET)
				send_random_buffer();
			wait_drained();
			quiet = 1'b0;
			phase++;
		end
	endtask

	initial begin
		int hold;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++)
					@(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
			end
		end
	end

	always @(posedge clk) begin : check_results
		word_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				e = expected_q.pop_front();
				if (m_axis_tuser != e.kind) begin
					$error("word_kind expected %0d got %0d", e.kind, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[0] != e.rejected) begin
					$error("event_rejected expected %0d got %0d", e.rejected, m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tlast != e.done) begin
					$error("buffer_done expected %0d got %0d", e.done, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tdata[2:1] != e.status) begin
					$error("buffer_status expected %0d got %0d", e.status, m_axis_tdata[2:1]);
					fail_count++;
				end
				if (m_axis_tdata[18:3] != e.events) begin
					$error("events_in_buffer expected %0d got %0d", e.events,
						m_axis_tdata[18:3]);
					fail_count++;
				end
				if (m_axis_tdata[50:19] != e.count) begin
					$error("bin_count expected %0d got %0d", e.count, m_axis_tdata[50:19]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_WORD;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		fail_count    = 0;
		items_sent    = 0;
		clears_left   = 0;
		cycle_count   = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		exp_words     = EXP_RESET;
		reset_parser();
		clear_hist();
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_setting();
		test_directed();
		test_short_events();
		test_longest_event();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (10)
			@(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
